@@ sv/qpct_pkg.sv @@
// ---------------------------------------------------------------------------
// qpct_pkg: shared types and constants of the credential table
// Beat layouts, result codes and the stored entry format.
// ---------------------------------------------------------------------------
package qpct_pkg;

	// Request beat: tuser holds the request kind, tdata the key and digest.
	localparam int KEY_W      = 64;
	localparam int DIG_HIGH_W = 64;
	localparam int DIG_MID_W  = 64;
	localparam int DIG_LOW_W  = 32;
	localparam int IN_DATA_W  = KEY_W + DIG_HIGH_W + DIG_MID_W + DIG_LOW_W;
	localparam int DIGEST_W   = DIG_HIGH_W + DIG_MID_W + DIG_LOW_W;

	// Result beat: tuser holds the outcome, tdata the slot and occupancy.
	localparam int OUTCOME_W  = 3;
	localparam int SLOT_OUT_W = 6;
	localparam int OCC_OUT_W  = 7;
	localparam int OUT_DATA_W = 16;

	// Eight squared bytes of at most 255*255 fit in twenty bits.
	localparam int SUM_W      = 20;

	typedef enum logic {
		KIND_REGISTER = 1'b0,
		KIND_LOGIN    = 1'b1
	} kind_t;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_STORED    = 3'd0,
		OUT_FULL      = 3'd1,
		OUT_ACCEPTED  = 3'd2,
		OUT_WRONG_PW  = 3'd3,
		OUT_UNKNOWN   = 3'd4
	} outcome_t;

	typedef struct packed {
		logic                  engaged;
		logic [KEY_W-1:0]      key;
		logic [DIG_HIGH_W-1:0] dig_high;
		logic [DIG_MID_W-1:0]  dig_mid;
		logic [DIG_LOW_W-1:0]  dig_low;
	} entry_t;

endpackage

@@ sv/quadratic_probe_credential_table.sv @@
// ---------------------------------------------------------------------------
// quadratic_probe_credential_table: hashed store of login credentials
// Open-addressing table with quadratic probing held in one on-chip memory.
// ---------------------------------------------------------------------------
// Usage
//   Requests arrive on the s_ stream: tuser selects register (0) or login (1),
//   tdata carries the NUL-padded login key and the 160-bit password digest.
//   Each request yields exactly one result beat on the m_ stream: tuser holds
//   the outcome code, tdata the slot used or matched and the new occupancy.
//   One request is worked on at a time. A request is captured, then its
//   squared key bytes are summed one byte per cycle through one 8x8
//   multiplier, the sum is reduced modulo the slot count (a reciprocal
//   multiply, then the remainder), and slots are then probed, one probe
//   address per cycle through the single memory read port, until a probe
//   hits or all TABLE_SLOTS probes miss; last the result register is loaded.
//   After reset the block sweeps the memory once to clear all occupancy
//   flags, one slot per cycle; s_tready stays low until that sweep is done.
//   Results sit in an output register. While the receiver stalls, the block
//   still takes the next request and works on it; it holds that result until
//   the output register frees up, and only then takes another request.
// ---------------------------------------------------------------------------
module quadratic_probe_credential_table #(
	parameter int TABLE_SLOTS = 64,
	parameter int KEY_CHARS   = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Request stream.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// tdata, low bit up: user_key[63:0], digest_high[127:64],
	// digest_mid[191:128], digest_low[223:192].
	input  logic [qpct_pkg::IN_DATA_W-1:0]     s_tdata,
	// tuser: kind[0].
	input  logic                               s_tuser,
	// Result stream.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// tdata, low bit up: slot[5:0], occupied[12:6], zero pad[15:13].
	output logic [qpct_pkg::OUT_DATA_W-1:0]    m_tdata,
	// tuser: outcome[2:0].
	output logic [qpct_pkg::OUTCOME_W-1:0]     m_tuser
);
	import qpct_pkg::*;

	localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);

	localparam logic [SLOT_W:0]    SLOTS_X   = (SLOT_W + 1)'(TABLE_SLOTS);
	localparam logic [CNT_W-1:0]   SLOTS_C   = CNT_W'(TABLE_SLOTS);
	localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

	// Reciprocal of the slot count, rounded up, scaled by 2**RECIP_K. With this
	// scale the quotient is exact for every sum below 2**SUM_W.
	localparam int                 RECIP_K   = SUM_W + SLOT_W;
	localparam int                 QUOT_W    = SUM_W + 1 - SLOT_W;
	localparam logic [SUM_W:0]     RECIP     = (SUM_W + 1)'(((64'd1 << RECIP_K) +
		64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS));
	localparam logic [SUM_W-1:0]   SLOTS_SUM = SUM_W'(TABLE_SLOTS);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_DIV,
		ST_MOD,
		ST_PROBE,
		ST_DONE
	} state_t;

	// The table itself: occupancy flag, key and digest per slot.
	entry_t mem [TABLE_SLOTS];

	state_t                 state_q;
	kind_t                  kind_q;
	logic [KEY_W-1:0]       key_q;
	logic [DIGEST_W-1:0]    dig_q;
	logic [2:0]             byte_idx_q;
	logic [SUM_W-1:0]       sum_q;
	logic [QUOT_W-1:0]      quot_q;
	logic [SLOT_W-1:0]      home_q;
	logic [SLOT_W-1:0]      sq_q;
	logic [SLOT_W-1:0]      odd_q;
	logic [CNT_W-1:0]       issued_q;
	logic [SLOT_W-1:0]      addr_s1;
	logic                   valid_s1;
	logic [CNT_W-1:0]       count_q;
	outcome_t               res_outcome_q;
	logic [SLOT_W-1:0]      res_slot_q;
	logic [SLOT_W-1:0]      clr_addr_q;
	logic                   m_tvalid_q;
	logic [SLOT_OUT_W-1:0]  out_slot_q;
	logic [OCC_OUT_W-1:0]   out_occ_q;
	outcome_t               out_outcome_q;
	entry_t                 rd_q;

	// Key normalization: bytes after the first NUL, or past KEY_CHARS, read as zero.
	logic [KEY_W-1:0]       norm_key;
	logic                   key_live;

	always_comb begin
		key_live = 1'b1;
		norm_key = '0;
		for (int b = 0; b < 8; b++) begin
			if (b < KEY_CHARS && key_live && s_tdata[8*b +: 8] != 8'h00) begin
				norm_key[8*b +: 8] = s_tdata[8*b +: 8];
			end else begin
				key_live = 1'b0;
			end
		end
	end

	// Hash: one squared key byte per cycle.
	logic [7:0]       hash_byte;
	logic [15:0]      hash_sq;
	logic [SUM_W-1:0] sum_next;

	assign hash_byte = key_q[{byte_idx_q, 3'b000} +: 8];
	assign hash_sq   = {8'h00, hash_byte} * {8'h00, hash_byte};
	assign sum_next  = sum_q + SUM_W'(hash_sq);

	// Modulo in two steps: the quotient from the reciprocal product, then the
	// sum minus quotient times slot count.
	logic [2*SUM_W:0]  recip_prod;
	logic [SUM_W-1:0]  quot_back;
	logic [SUM_W-1:0]  sum_rem;

	assign recip_prod = {{(SUM_W + 1){1'b0}}, sum_q} * {{SUM_W{1'b0}}, RECIP};
	assign quot_back  = SUM_W'(quot_q) * SLOTS_SUM;
	assign sum_rem    = sum_q - quot_back;

	// Probe address home + i*i, with i*i tracked as a running sum of odd steps,
	// all kept below the slot count by one conditional subtract each.
	logic [SLOT_W:0]   probe_sum;
	logic [SLOT_W:0]   probe_fix;
	logic [SLOT_W:0]   sq_sum;
	logic [SLOT_W:0]   sq_fix;
	logic [SLOT_W:0]   odd_sum;
	logic [SLOT_W:0]   odd_fix;
	logic [SLOT_W-1:0] probe_addr;
	logic              issue;

	assign probe_sum  = {1'b0, home_q} + {1'b0, sq_q};
	assign probe_fix  = (probe_sum >= SLOTS_X) ? (probe_sum - SLOTS_X) : probe_sum;
	assign probe_addr = probe_fix[SLOT_W-1:0];
	assign sq_sum     = {1'b0, sq_q} + {1'b0, odd_q};
	assign sq_fix     = (sq_sum >= SLOTS_X) ? (sq_sum - SLOTS_X) : sq_sum;
	assign odd_sum    = {1'b0, odd_q} + (SLOT_W + 1)'(2);
	assign odd_fix    = (odd_sum >= SLOTS_X) ? (odd_sum - SLOTS_X) : odd_sum;
	assign issue      = (state_q == ST_PROBE) && (issued_q != SLOTS_C);

	// Evaluation of the slot read in the previous cycle.
	logic key_hit;
	logic dig_hit;
	logic hit;
	logic exhausted;

	assign key_hit   = rd_q.engaged && (rd_q.key == key_q);
	assign dig_hit   = ({rd_q.dig_high, rd_q.dig_mid, rd_q.dig_low} == dig_q);
	assign hit       = valid_s1 && ((kind_q == KIND_REGISTER) ? !rd_q.engaged : key_hit);
	assign exhausted = !valid_s1 && (issued_q == SLOTS_C);

	// Memory port controls: the clearing sweep, or the store of a new entry.
	logic              wr_en;
	logic [SLOT_W-1:0] wr_addr;
	entry_t            wr_data;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_s1;
		wr_data = '{engaged: 1'b1, key: key_q, dig_high: dig_q[DIGEST_W-1 -: DIG_HIGH_W],
			dig_mid: dig_q[DIG_LOW_W +: DIG_MID_W], dig_low: dig_q[DIG_LOW_W-1:0]};
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else if (state_q == ST_PROBE && hit && kind_q == KIND_REGISTER) begin
			wr_en   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[probe_addr];
	end

	// Output fields resized to the fixed port widths.
	logic [SLOT_W+SLOT_OUT_W-1:0] slot_wide;
	logic [CNT_W+OCC_OUT_W-1:0]   occ_wide;

	assign slot_wide = {{SLOT_OUT_W{1'b0}}, res_slot_q};
	assign occ_wide  = {{OCC_OUT_W{1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			kind_q        <= KIND_REGISTER;
			key_q         <= '0;
			dig_q         <= '0;
			byte_idx_q    <= '0;
			sum_q         <= '0;
			quot_q        <= '0;
			home_q        <= '0;
			sq_q          <= '0;
			odd_q         <= '0;
			issued_q      <= '0;
			addr_s1       <= '0;
			valid_s1      <= 1'b0;
			count_q       <= '0;
			res_outcome_q <= OUT_STORED;
			res_slot_q    <= '0;
			clr_addr_q    <= '0;
			m_tvalid_q    <= 1'b0;
			out_slot_q    <= '0;
			out_occ_q     <= '0;
			out_outcome_q <= OUT_STORED;
		end else begin
			if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q    <= 1'b1;
				out_outcome_q <= res_outcome_q;
				out_slot_q    <= slot_wide[SLOT_OUT_W-1:0];
				out_occ_q     <= occ_wide[OCC_OUT_W-1:0];
			end else if (m_tready) begin
				m_tvalid_q    <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_SLOT) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						kind_q     <= kind_t'(s_tuser);
						key_q      <= norm_key;
						dig_q      <= {s_tdata[KEY_W +: DIG_HIGH_W],
							s_tdata[KEY_W+DIG_HIGH_W +: DIG_MID_W],
							s_tdata[KEY_W+DIG_HIGH_W+DIG_MID_W +: DIG_LOW_W]};
						sum_q      <= '0;
						byte_idx_q <= '0;
						state_q    <= ST_HASH;
					end
				end
				ST_HASH: begin
					sum_q      <= sum_next;
					byte_idx_q <= byte_idx_q + 1'b1;
					if (byte_idx_q == 3'd7) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					quot_q  <= recip_prod[2*SUM_W:RECIP_K];
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					home_q   <= sum_rem[SLOT_W-1:0];
					sq_q     <= '0;
					odd_q    <= SLOT_W'(1);
					issued_q <= '0;
					valid_s1 <= 1'b0;
					state_q  <= ST_PROBE;
				end
				ST_PROBE: begin
					// One slot read issued per cycle; the one in flight when a
					// hit is seen is simply dropped.
					valid_s1 <= issue;
					addr_s1  <= probe_addr;
					if (issue) begin
						sq_q     <= sq_fix[SLOT_W-1:0];
						odd_q    <= odd_fix[SLOT_W-1:0];
						issued_q <= issued_q + 1'b1;
					end
					if (hit) begin
						res_slot_q <= addr_s1;
						if (kind_q == KIND_REGISTER) begin
							res_outcome_q <= OUT_STORED;
							count_q       <= count_q + 1'b1;
						end else begin
							res_outcome_q <= dig_hit ? OUT_ACCEPTED : OUT_WRONG_PW;
						end
						state_q <= ST_DONE;
					end else if (exhausted) begin
						res_slot_q    <= '0;
						res_outcome_q <= (kind_q == KIND_REGISTER) ? OUT_FULL : OUT_UNKNOWN;
						state_q       <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_outcome_q;
	assign m_tdata  = {{(OUT_DATA_W - SLOT_OUT_W - OCC_OUT_W){1'b0}}, out_occ_q, out_slot_q};

endmodule

@@ sv/qpct_checker.sv @@
// ---------------------------------------------------------------------------
// qpct_checker: port-level checks of the credential table
// Watches the request and result streams over time.
// ---------------------------------------------------------------------------
module qpct_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [qpct_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [qpct_pkg::OUTCOME_W-1:0]  m_tuser
);
	import qpct_pkg::*;

	// A stalled result beat keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// Requests are handled one at a time: no back-to-back acceptance.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is in work");

	// A result is only loaded while no request can be taken.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without a request in work");

	// Failed lookups and full-table registers report slot zero.
	a_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == OUT_FULL || m_tuser == OUT_UNKNOWN)
		|-> m_tdata[SLOT_OUT_W-1:0] == '0)
		else $error("nonzero slot on a miss");

endmodule

bind quadratic_probe_credential_table qpct_checker u_qpct_checker (.*);
